FILE: hw/rtl/flac_header_parser_assert.svh
// ----------------------------------------------------------------------------
// FLAC header parser assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FLAC_HEADER_PARSER_ASSERT_SVH
`define FLAC_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH
`define FHP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flac_header_parser assertion failed");
`define FHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flac_header_parser assertion failed");
`else
`define FHP_ASSERT_IMPLIES(lbl, ante, cons)
`define FHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/fhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLAC header parser package
// Parse phases, status codes and field constants shared by the parser.
// ----------------------------------------------------------------------------
package fhp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_HEADER = 3'd1,
        PH_SKIP   = 3'd2,
        PH_INFO   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_NO_INFO   = 3'd3;
    localparam logic [2:0] ST_EARLY_END = 3'd4;

    localparam int CNT_W      = 24;
    localparam int INFO_LEN   = 34;
    localparam int INFO_HIST  = (INFO_LEN - 1) * 8;
    localparam int INFO_BITS  = INFO_LEN * 8;
    localparam int RESULT_W   = 277;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] INFO_LEN_C = CNT_W'(INFO_LEN);

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h66;
            2'd1:    val = 8'h4C;
            2'd2:    val = 8'h61;
            default: val = 8'h43;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/flac_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLAC header parser
// Checks the fLaC magic, walks metadata block headers and reports STREAMINFO.
// ----------------------------------------------------------------------------
// The parser takes one file byte per transaction and can take a new byte every
// cycle while no result waits on a stalled output: each byte passes an input
// register, then one step of the parse state machine, and a finished result
// lands in an output register; while a result waits, only one more byte is
// taken, into the input register. Each file yields exactly one result
// transaction, success with all STREAMINFO fields or an error code with every
// other field zero; bytes after the result are dropped until tuser marks the
// first byte of the next file. The STREAMINFO body is held in a 33-byte shift
// register and unpacked together with its final byte.
`include "flac_header_parser_assert.svh"

module flac_header_parser
    import fhp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tuser,   // stream_start
    input  logic                   s_axis_tlast,   // stream_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status, min_block_size, max_block_size, min_frame_size, max_frame_size,
    // sample_rate, channel_count, sample_bits, total_samples, md5_high,
    // md5_low, zero padding
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;
    logic                   in_end_reg;

    phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       blen_reg, blen_next;
    logic                   last_reg, last_next;
    logic                   found_reg, found_next;
    logic [INFO_HIST-1:0]   info_reg, info_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                   adv;
    phase_t                 ph;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       blen;
    logic                   lastf;
    logic                   found;
    logic [CNT_W-1:0]       cnt_inc;
    logic [CNT_W-1:0]       blen_shift;
    logic [INFO_BITS-1:0]   info_all;
    logic                   emit;
    logic                   emit_info;
    logic [2:0]             err_code;
    logic [RESULT_W-1:0]    info_result;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign ph    = in_start_reg ? PH_MAGIC : phase_reg;
    assign cnt   = in_start_reg ? '0 : cnt_reg;
    assign blen  = in_start_reg ? '0 : blen_reg;
    assign lastf = in_start_reg ? 1'b0 : last_reg;
    assign found = in_start_reg ? 1'b0 : found_reg;

    assign cnt_inc    = cnt + CNT_W'(1);
    assign blen_shift = {blen[CNT_W-9:0], in_byte_reg};
    assign info_all   = {info_reg, in_byte_reg};

    assign info_result = {
        info_all[63:0],
        info_all[127:64],
        info_all[163:128],
        {1'b0, info_all[168:164]} + 6'd1,
        {1'b0, info_all[171:169]} + 4'd1,
        info_all[191:172],
        info_all[215:192],
        info_all[239:216],
        info_all[255:240],
        info_all[271:256],
        ST_OK
    };

    always_comb
    begin
        phase_next = ph;
        cnt_next   = cnt;
        blen_next  = blen;
        last_next  = lastf;
        found_next = found;
        info_next  = info_reg;
        emit       = 1'b0;
        emit_info  = 1'b0;
        err_code   = ST_OK;

        unique case (ph)
            PH_MAGIC:
            begin
                if (in_byte_reg != magic_byte(cnt[1:0]))
                begin
                    emit     = 1'b1;
                    err_code = ST_BAD_MAGIC;
                end
                else if (cnt >= CNT_W'(3))
                begin
                    phase_next = PH_HEADER;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_HEADER:
            begin
                if (cnt == '0)
                begin
                    last_next  = in_byte_reg[7];
                    found_next = (in_byte_reg[6:0] == 7'd0);
                    blen_next  = '0;
                    cnt_next   = CNT_W'(1);
                end
                else
                begin
                    blen_next = blen_shift;
                    if (cnt < CNT_W'(3))
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        cnt_next = '0;
                        if (found)
                        begin
                            if (blen_shift != INFO_LEN_C)
                            begin
                                emit     = 1'b1;
                                err_code = ST_BAD_LEN;
                            end
                            else
                            begin
                                phase_next = PH_INFO;
                            end
                        end
                        else if (blen_shift == '0)
                        begin
                            if (lastf)
                            begin
                                emit     = 1'b1;
                                err_code = ST_NO_INFO;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= blen)
                begin
                    if (lastf)
                    begin
                        emit     = 1'b1;
                        err_code = ST_NO_INFO;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                    end
                end
            end
            PH_INFO:
            begin
                info_next = info_all[INFO_HIST-1:0];
                cnt_next  = cnt_inc;
                if (cnt_inc >= INFO_LEN_C)
                begin
                    emit      = 1'b1;
                    emit_info = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            phase_next = PH_DONE;
        end
        else if (in_end_reg && phase_next != PH_DONE)
        begin
            emit       = 1'b1;
            err_code   = (phase_next == PH_MAGIC) ? ST_BAD_MAGIC : ST_EARLY_END;
            phase_next = PH_DONE;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (adv)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                if (emit_info)
                begin
                    out_data_next = OUT_TDATA_W'(info_result);
                end
                else
                begin
                    out_data_next = OUT_TDATA_W'(err_code);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_MAGIC;
            cnt_reg       <= '0;
            blen_reg      <= '0;
            last_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                blen_reg  <= blen_next;
                last_reg  <= last_next;
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
            in_end_reg   <= s_axis_tlast;
        end
        if (adv)
        begin
            info_reg <= info_next;
        end
    end

    `FHP_ASSERT_NEXT(a_result_ends_parse, adv && emit, phase_reg == PH_DONE)
    `FHP_ASSERT_IMPLIES(a_error_fields_zero, out_valid_reg && out_data_reg[2:0] != ST_OK,
                        out_data_reg[OUT_TDATA_W-1:3] == '0)
    `FHP_ASSERT_IMPLIES(a_info_count, phase_reg == PH_INFO, cnt_reg < INFO_LEN_C)
    `FHP_ASSERT_IMPLIES(a_skip_len_nonzero, phase_reg == PH_SKIP, blen_reg != '0)
    `FHP_ASSERT_IMPLIES(a_magic_count, phase_reg == PH_MAGIC, cnt_reg < CNT_W'(4))

endmodule
